// File: hw/rtl/wildcard_byte_pattern_scanner_macros.svh
// Assertion helpers shared by the scanner RTL.
// Both forms sample on aclk and are switched off while aresetn is low.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_MACROS_SVH

`ifndef SYNTHESIS

`define WBPS_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("scanner invariant violated");

`define WBPS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scanner sequence violated");

`else

`define WBPS_ASSERT_ALWAYS(name, cond)

`define WBPS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// File: hw/rtl/wbps_pkg.sv
package wbps_pkg;

    // Largest pattern the window can hold, and the width of region offsets.
    localparam int MAX_PATTERN_BYTES = 16;
    localparam int OFFSET_BITS       = 31;

    // Pattern bytes that the configuration registers can hold.
    localparam int PATTERN_REG_BYTES = 16;

    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 64;
    localparam int CARE_MASK_BITS  = 16;
    localparam int CFG_LENGTH_BITS = 5;

    localparam int LEN_BITS = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_BITS = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

    // Configuration register indices.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CARE_MASK    = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LEN  = 2'd3;

    localparam logic [CFG_DATA_BITS-1:0]   PATTERN_RESET   = '0;
    localparam logic [CARE_MASK_BITS-1:0]  CARE_MASK_RESET = '1;
    localparam logic [CFG_LENGTH_BITS-1:0] LENGTH_RESET    = 5'd1;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0]   pattern_low;
        logic [CFG_DATA_BITS-1:0]   pattern_high;
        logic [CARE_MASK_BITS-1:0]  care_mask;
        logic [CFG_LENGTH_BITS-1:0] pattern_length;
    } cfg_t;

    // One registered input byte presented to the scan core.
    typedef struct packed {
        logic       step;
        logic [7:0] data_byte;
        logic       region_end;
    } step_t;

    typedef struct packed {
        logic                   valid;
        logic                   found;
        logic [OFFSET_BITS-1:0] match_offset;
    } result_t;

endpackage

// File: hw/rtl/wbps_cfg_regs.sv
module wbps_cfg_regs (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [wbps_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [wbps_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    output wbps_pkg::cfg_t                         cfg
);

    wbps_pkg::cfg_t cfg_reg;
    wbps_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                wbps_pkg::CFG_PATTERN_LOW: begin
                    cfg_next.pattern_low = cfg_data;
                end
                wbps_pkg::CFG_PATTERN_HIGH: begin
                    cfg_next.pattern_high = cfg_data;
                end
                wbps_pkg::CFG_CARE_MASK: begin
                    cfg_next.care_mask = cfg_data[wbps_pkg::CARE_MASK_BITS-1:0];
                end
                wbps_pkg::CFG_PATTERN_LEN: begin
                    cfg_next.pattern_length = cfg_data[wbps_pkg::CFG_LENGTH_BITS-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_low    <= wbps_pkg::PATTERN_RESET;
            cfg_reg.pattern_high   <= wbps_pkg::PATTERN_RESET;
            cfg_reg.care_mask      <= wbps_pkg::CARE_MASK_RESET;
            cfg_reg.pattern_length <= wbps_pkg::LENGTH_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hw/rtl/wbps_scan_core.sv
module wbps_scan_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  wbps_pkg::cfg_t    cfg,
    input  wbps_pkg::step_t   step,
    output wbps_pkg::result_t result,
    output logic              matched
);

    logic [7:0]                       win_reg  [wbps_pkg::MAX_PATTERN_BYTES];
    logic [7:0]                       win_next [wbps_pkg::MAX_PATTERN_BYTES];
    logic [wbps_pkg::OFFSET_BITS-1:0] count_reg;
    logic [wbps_pkg::OFFSET_BITS-1:0] count_next;
    logic                             matched_reg;
    logic                             matched_next;

    logic [wbps_pkg::LEN_BITS-1:0]    len_eff;
    logic [wbps_pkg::OFFSET_BITS-1:0] len_off;
    logic [wbps_pkg::OFFSET_BITS-1:0] count_inc;
    logic [8*wbps_pkg::PATTERN_REG_BYTES-1:0] pattern;
    logic                             hit;
    logic                             count_ok;
    logic                             found;

    assign matched = matched_reg;
    assign pattern = {cfg.pattern_high, cfg.pattern_low};

    // A length of zero behaves as one; anything above the window depth is clipped.
    always_comb begin
        if (cfg.pattern_length == '0) begin
            len_eff = wbps_pkg::LEN_BITS'(1);
        end else if (int'(cfg.pattern_length) > wbps_pkg::MAX_PATTERN_BYTES) begin
            len_eff = wbps_pkg::LEN_BITS'(wbps_pkg::MAX_PATTERN_BYTES);
        end else begin
            len_eff = wbps_pkg::LEN_BITS'(cfg.pattern_length);
        end
    end

    assign len_off   = wbps_pkg::OFFSET_BITS'(len_eff);
    assign count_inc = (count_reg == wbps_pkg::COUNT_MAX) ? count_reg
                                                         : count_reg + 1'b1;

    // The window after this byte has been shifted in; entry 0 is the newest byte.
    always_comb begin
        win_next[0] = step.data_byte;
        for (int i = 1; i < wbps_pkg::MAX_PATTERN_BYTES; i++) begin
            win_next[i] = win_reg[i-1];
        end
    end

    // Pattern byte i lines up with the byte that arrived len-1-i bytes ago.
    always_comb begin
        logic [wbps_pkg::LEN_BITS-1:0] sel;
        hit = 1'b1;
        sel = '0;
        for (int i = 0; i < wbps_pkg::MAX_PATTERN_BYTES; i++) begin
            if (i < wbps_pkg::PATTERN_REG_BYTES && wbps_pkg::LEN_BITS'(i) < len_eff) begin
                sel = len_eff - wbps_pkg::LEN_BITS'(1) - wbps_pkg::LEN_BITS'(i);
                if (cfg.care_mask[i] &&
                    win_next[sel[wbps_pkg::IDX_BITS-1:0]] != pattern[8*i +: 8]) begin
                    hit = 1'b0;
                end
            end
        end
    end

    assign count_ok = (count_inc >= len_off);
    assign found    = count_ok && hit;

    always_comb begin
        result.valid        = step.step && !matched_reg && (found || step.region_end);
        result.found        = found;
        result.match_offset = found ? (count_inc - len_off) : '0;
    end

    always_comb begin
        count_next   = count_reg;
        matched_next = matched_reg;
        if (step.step) begin
            if (!matched_reg) begin
                count_next   = count_inc;
                matched_next = found;
            end
            if (step.region_end) begin
                count_next   = '0;
                matched_next = 1'b0;
            end
        end
    end

    // The window needs no clearing: a match is only tested once the whole
    // pattern length has been filled from the current region.
    always_ff @(posedge aclk) begin
        if (step.step && !matched_reg) begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            matched_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            matched_reg <= matched_next;
        end
    end

endmodule

// File: hw/rtl/wildcard_byte_pattern_scanner.sv
// Wildcard byte pattern scanner.
//
// Region bytes arrive on the s_ channel, one byte per transaction, with
// s_region_end marking the last byte of a region. The pattern, its care mask
// (a clear bit makes that pattern byte a wildcard) and its length are written
// beforehand through the cfg_ write channel, which is always ready.
// For each region the m_ channel carries exactly one transaction: found = 1
// with the offset of the first byte of the first match, or found = 0 with
// offset 0 on the region's last byte when nothing matched. Bytes after a
// match are consumed silently until the region ends.
// An accepted byte is held in the input register, compared when it moves on,
// and its result, if any, is held in the result register for the m_ ports.
// Throughput: one byte per cycle unless a result stalls; the window compare of
// all pattern bytes is a single stage between the input and result registers.
// When the receiver stalls, the pending result holds and one further byte is
// kept in the input register; s_ready falls only once both are occupied.
// Reset (aresetn low, synchronous) empties both registers, clears the scan
// state and returns the pattern to zeros, all bytes cared, length one.
`include "wildcard_byte_pattern_scanner_macros.svh"

module wildcard_byte_pattern_scanner (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [wbps_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [wbps_pkg::CFG_DATA_BITS-1:0]      cfg_data,

    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [7:0]                              s_data_byte,
    input  logic                                    s_region_end,

    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_found,
    output logic [wbps_pkg::OFFSET_BITS-1:0]        m_match_offset
);

    wbps_pkg::cfg_t    cfg;
    wbps_pkg::step_t   step;
    wbps_pkg::result_t result;
    logic              matched;

    // Input register: holds one accepted byte until the scan core takes it.
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    // Result register: holds one result until the receiver takes it.
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             out_found_reg;
    logic [wbps_pkg::OFFSET_BITS-1:0] out_offset_reg;

    logic process;

    wbps_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The held byte moves on whenever the result register is free or is
    // being emptied in this same cycle.
    assign process = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || process;

    always_comb begin
        step.step       = process;
        step.data_byte  = in_byte_reg;
        step.region_end = in_end_reg;
    end

    wbps_scan_core u_scan_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (step),
        .result  (result),
        .matched (matched)
    );

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (process) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    // A new result can only appear when the register is free or draining.
    assign out_valid_next = (out_valid_reg && !m_ready) || result.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_end_reg  <= s_region_end;
        end
        if (result.valid) begin
            out_found_reg  <= result.found;
            out_offset_reg <= result.match_offset;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_found        = out_found_reg;
    assign m_match_offset = out_offset_reg;

    // A not-found result always carries a zero offset.
    `WBPS_ASSERT_ALWAYS(a_notfound_offset_zero, !(out_valid_reg && !m_found) || (m_match_offset == '0))
    // A match before the end of a region locks the scan for the rest of it.
    `WBPS_ASSERT_NEXT(a_match_locks_scan, result.valid && result.found && !in_end_reg, matched)
    // The last byte of a region always leaves the scan unlocked for the next.
    `WBPS_ASSERT_NEXT(a_end_clears_scan, process && in_end_reg, !matched)

endmodule
